FILE: hw/rtl/bap_pkg.sv
// ----------------------------------------------------------------------------
// Button auto-repeat pulser package
// Shared constants, beat types and the per-button state entry.
// ----------------------------------------------------------------------------
package bap_pkg;

  // Number of buttons kept in the state memory, and the hold counter width.
  localparam int unsigned NUM_BUTTONS = 12;
  localparam int unsigned COUNT_BITS  = 16;

  // Buttons that have an input line; further buttons read as released.
  localparam int unsigned NUM_INPUT_BUTTONS = 12;
  localparam int unsigned PULSE_W           = 12;

  localparam int unsigned IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FRAMES   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_FRAMES = 1'b1;
  localparam logic [7:0] WAIT_RESET   = 8'd14;
  localparam logic [7:0] REPEAT_RESET = 8'd7;

  // Console switch byte bit positions.
  localparam int unsigned CONS_RESET_BIT  = 0;
  localparam int unsigned CONS_SELECT_BIT = 1;
  localparam int unsigned CONS_COLOUR_BIT = 3;
  localparam int unsigned CONS_LEFT_BIT   = 6;
  localparam int unsigned CONS_RIGHT_BIT  = 7;

  typedef struct packed {
    logic [7:0] stick_lines;
    logic       fire_left_n;
    logic       fire_right_n;
    logic [7:0] console_switches;
  } in_t;

  typedef struct packed {
    logic [PULSE_W-1:0] press_pulses;
    logic               colour_mode;
    logic               left_difficulty;
    logic               right_difficulty;
  } out_t;

  // One word of the state memory: the state of one button.
  typedef struct packed {
    logic [COUNT_BITS-1:0] hold_count;
    logic [COUNT_BITS-1:0] next_fire_at;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: hw/rtl/button_autorepeat_pulser_core.sv
// ----------------------------------------------------------------------------
// Button auto-repeat pulser core
// Typematic auto-repeat for twelve active-low buttons, one beat per frame.
// ----------------------------------------------------------------------------
// Usage. One input beat carries the frame's button sample (stick byte, two
// fire levels and the console switch byte). For each input beat exactly one
// output beat is given, carrying one pulse bit per button and the three
// console level switches. Both channels use valid/ready.
// The per-button state (hold counter and next firing count) lives in a small
// synchronous RAM. After a beat is taken the block sweeps the buttons, one
// entry per cycle while the output does not stall: a read in one cycle, then
// update and write-back in the next. The output beat is registered after the
// last entry's write-back. A new input beat is taken in the cycle that the
// last entry is read, so the next sweep overlaps the end of the previous
// one; the single read port of the state RAM sets the rate.
// The output register holds a finished beat while the receiver stalls; the
// sweep of the next beat carries on and only halts at its last write-back
// until the output register is free, which also stops further input beats.
// Reset clears the per-entry valid bits, so every button starts with zero
// state, and loads the wait and repeat registers with 14 and 7 frames.
// Configuration writes are taken at any time and are meant for idle periods.
// ----------------------------------------------------------------------------
module button_autorepeat_pulser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bap_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bap_pkg::out_t                     out_data_o,
  input  logic                              cfg_we_i,
  input  logic [bap_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bap_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bap_pkg::*;

  // Configuration registers.
  logic [7:0] wait_q, wait_d;
  logic [7:0] repeat_q, repeat_d;

  // Sweep (read stage) control.
  logic                   busy_q, busy_d;
  logic [IDX_W-1:0]       rd_idx_q, rd_idx_d;
  logic [NUM_BUTTONS-1:0] pressed_q, pressed_d;
  logic [2:0]             cons_q, cons_d;

  // Update stage, in the cycle after the read.
  logic                   s2_valid_q, s2_valid_d;
  logic                   s2_last_q, s2_last_d;
  logic [IDX_W-1:0]       s2_idx_q, s2_idx_d;
  logic                   s2_pressed_q, s2_pressed_d;
  logic [2:0]             s2_cons_q, s2_cons_d;
  logic                   s2_vld_q, s2_vld_d;
  logic                   fwd_q, fwd_d;
  entry_t                 fwd_data_q, fwd_data_d;
  logic [NUM_BUTTONS-1:0] acc_q, acc_d;
  logic [NUM_BUTTONS-1:0] ent_vld_q, ent_vld_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;

  logic                   stall;
  logic                   accept;
  logic                   ram_re;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_rdata;
  entry_t                 entry_cur;
  entry_t                 entry_new;
  logic                   fire;
  logic [NUM_BUTTONS-1:0] acc_next;
  logic [PULSE_W-1:0]     pulses;
  logic [NUM_INPUT_BUTTONS-1:0] raw_levels;
  logic [NUM_BUTTONS-1:0] in_pressed;

  // Button levels in button order: stick byte, left fire, right fire, reset, select.
  assign raw_levels = {in_data_i.console_switches[CONS_SELECT_BIT],
                       in_data_i.console_switches[CONS_RESET_BIT],
                       in_data_i.fire_right_n, in_data_i.fire_left_n,
                       in_data_i.stick_lines};

  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_press
    if (g < NUM_INPUT_BUTTONS) begin : g_wired
      assign in_pressed[g] = ~raw_levels[g];
    end else begin : g_open
      assign in_pressed[g] = 1'b0;
    end
  end

  // The last write-back of a sweep waits while the output register is full.
  assign stall      = s2_valid_q && s2_last_q && out_valid_q && !out_ready_i;
  assign in_ready_o = (!busy_q || (rd_idx_q == LAST_IDX)) && !stall;
  assign accept     = in_valid_i && in_ready_o;
  assign ram_re     = busy_q && !stall;
  assign ram_we     = s2_valid_q && !stall;

  bap_ram #(
    .DEPTH (NUM_BUTTONS),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_idx_q),
    .wdata_i (entry_new),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // A write to the entry being read in the same cycle is forwarded; an entry
  // never written since reset reads as zero.
  always_comb begin
    if (fwd_q) begin
      entry_cur = fwd_data_q;
    end else if (s2_vld_q) begin
      entry_cur = entry_t'(ram_rdata);
    end else begin
      entry_cur = '0;
    end
  end

  bap_update u_update (
    .pressed_i       (s2_pressed_q),
    .entry_i         (entry_cur),
    .wait_frames_i   (wait_q),
    .repeat_frames_i (repeat_q),
    .entry_o         (entry_new),
    .fire_o          (fire)
  );

  // Pulse bits collect over the sweep, starting afresh at button zero.
  assign acc_next = ((s2_idx_q == '0) ? '0 : acc_q)
                  | (fire ? (NUM_BUTTONS'(1) << s2_idx_q) : '0);

  for (genvar g = 0; g < PULSE_W; g++) begin : g_pulse
    if (g < NUM_BUTTONS) begin : g_used
      assign pulses[g] = acc_next[g];
    end else begin : g_none
      assign pulses[g] = 1'b0;
    end
  end

  always_comb begin
    wait_d   = wait_q;
    repeat_d = repeat_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WAIT_FRAMES:   wait_d   = cfg_data_i;
        CFG_REPEAT_FRAMES: repeat_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    busy_d       = busy_q;
    rd_idx_d     = rd_idx_q;
    pressed_d    = pressed_q;
    cons_d       = cons_q;
    s2_valid_d   = s2_valid_q;
    s2_last_d    = s2_last_q;
    s2_idx_d     = s2_idx_q;
    s2_pressed_d = s2_pressed_q;
    s2_cons_d    = s2_cons_q;
    s2_vld_d     = s2_vld_q;
    fwd_d        = fwd_q;
    fwd_data_d   = fwd_data_q;
    acc_d        = acc_q;
    ent_vld_d    = ent_vld_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (!stall) begin
      // Read stage.
      s2_valid_d = ram_re;
      if (ram_re) begin
        s2_idx_d     = rd_idx_q;
        s2_last_d    = (rd_idx_q == LAST_IDX);
        s2_pressed_d = pressed_q[rd_idx_q];
        s2_cons_d    = cons_q;
        s2_vld_d     = ent_vld_q[rd_idx_q];
        fwd_d        = ram_we && (s2_idx_q == rd_idx_q);
        fwd_data_d   = entry_new;
        if (rd_idx_q == LAST_IDX) begin
          busy_d   = 1'b0;
          rd_idx_d = '0;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      if (accept) begin
        busy_d    = 1'b1;
        rd_idx_d  = '0;
        pressed_d = in_pressed;
        cons_d    = {in_data_i.console_switches[CONS_COLOUR_BIT],
                     in_data_i.console_switches[CONS_LEFT_BIT],
                     in_data_i.console_switches[CONS_RIGHT_BIT]};
      end

      // Update stage.
      if (s2_valid_q) begin
        acc_d               = acc_next;
        ent_vld_d[s2_idx_q] = 1'b1;
        if (s2_last_q) begin
          out_valid_d                 = 1'b1;
          out_data_d.press_pulses     = pulses;
          out_data_d.colour_mode      = s2_cons_q[2];
          out_data_d.left_difficulty  = s2_cons_q[1];
          out_data_d.right_difficulty = s2_cons_q[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q      <= WAIT_RESET;
      repeat_q    <= REPEAT_RESET;
      busy_q      <= 1'b0;
      rd_idx_q    <= '0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      s2_idx_q    <= '0;
      s2_vld_q    <= 1'b0;
      fwd_q       <= 1'b0;
      ent_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wait_q      <= wait_d;
      repeat_q    <= repeat_d;
      busy_q      <= busy_d;
      rd_idx_q    <= rd_idx_d;
      s2_valid_q  <= s2_valid_d;
      s2_last_q   <= s2_last_d;
      s2_idx_q    <= s2_idx_d;
      s2_vld_q    <= s2_vld_d;
      fwd_q       <= fwd_d;
      ent_vld_q   <= ent_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pressed_q    <= pressed_d;
    cons_q       <= cons_d;
    s2_pressed_q <= s2_pressed_d;
    s2_cons_q    <= s2_cons_d;
    fwd_data_q   <= fwd_data_d;
    acc_q        <= acc_d;
    out_data_q   <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A finished sweep that is not held back lands in the output register.
  a_sweep_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_last_q && !stall |=> out_valid_q)
    else $error("finished sweep did not reach the output register");

  // A read of the entry being written is always followed by its forwarded update.
  a_forward : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re && ram_we && (rd_idx_q == s2_idx_q) |=> s2_valid_q && fwd_q)
    else $error("same-entry read and write not forwarded");

  // A new beat is only taken when the sweep is idle or reading its last entry.
  a_accept_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !busy_q || (rd_idx_q == LAST_IDX))
    else $error("input beat taken in the middle of a sweep");

  // While stalled, the state RAM is neither read nor written.
  a_stall_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(ram_rdata) && $stable(s2_idx_q))
    else $error("state RAM moved during an output stall");

endmodule

FILE: hw/rtl/bap_ram.sv
// ----------------------------------------------------------------------------
// Button auto-repeat pulser state RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bap_ram #(
  parameter int unsigned DEPTH  = 12,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bap_update.sv
// ----------------------------------------------------------------------------
// Button auto-repeat pulser entry update
// Advances the hold counter of one button and decides whether it fires.
// ----------------------------------------------------------------------------
module bap_update (
  input  logic            pressed_i,
  input  bap_pkg::entry_t entry_i,
  input  logic [7:0]      wait_frames_i,
  input  logic [7:0]      repeat_frames_i,
  output bap_pkg::entry_t entry_o,
  output logic            fire_o
);
  import bap_pkg::*;

  logic [COUNT_BITS-1:0] hold_inc;
  logic [COUNT_BITS-1:0] target;
  logic                  first;

  assign hold_inc = entry_i.hold_count + 1'b1;
  assign first    = (hold_inc == COUNT_BITS'(1));
  // A first press reloads the target before it is compared, so a zero wait
  // fires once and arms the repeat in the same frame.
  assign target   = first ? (COUNT_BITS'(wait_frames_i) + 1'b1) : entry_i.next_fire_at;

  always_comb begin
    entry_o = entry_i;
    fire_o  = 1'b0;
    if (pressed_i) begin
      entry_o.hold_count   = hold_inc;
      entry_o.next_fire_at = target;
      fire_o               = first;
      if (hold_inc == target) begin
        fire_o               = 1'b1;
        entry_o.next_fire_at = target + COUNT_BITS'(repeat_frames_i) + 1'b1;
      end
    end else begin
      entry_o.hold_count = '0;
    end
  end

endmodule
